@@ rtl/core/i2ccrc_pkg.sv @@
// Shared constants, types and CRC helper for the I2C register CRC-8 framer.
`timescale 1ns / 1ps

package i2ccrc_pkg;

   // CRC-8 polynomial, MSB first, no reflection
   localparam logic [7:0] CRC_POLY = 8'h7F;

   // Command codes carried in req_tuser
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // Configuration register byte addresses
   localparam int          CSR_ADDR_W          = 3;
   localparam logic [2:0]  CSR_DEVICE_ADDRESS  = 3'd0;
   localparam int          CSR_DATA_W          = 32;
   localparam int          DEV_ADDR_W          = 7;

   // Stream widths
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   // Input item after unpacking
   typedef struct packed {
      logic       command;
      logic [7:0] register_address;
      logic [7:0] data_byte;
      logic       first_of_transfer;
      logic       end_of_register;
      logic       end_of_transfer;
   } req_item_type;

   // One result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_crc_byte;
      logic       crc_match;
      logic       transfer_ok;
      logic       last;
   } rsp_item_type;

   // Feed one byte into the CRC, eight shift steps
   function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] v;
      v = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         if (v[7]) begin
            v = {v[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

@@ rtl/core/i2c_register_crc8_framer.sv @@
// Top level of the I2C register CRC-8 framer and checker.
// Path: an accepted item passes through the input register, then the result register;
//   a write-mode closing item shows its CRC byte after its data byte, from the second slot.
// Throughput: one item per cycle while the result port is not stalled; an item that closes
//   a write register also sends its CRC byte, which holds off the next item.
// Reset: synchronous, active high; clears the stream valids and the running CRC,
//   sets the transfer-good flag and zeroes the device address.
`timescale 1ns / 1ps

module i2c_register_crc8_framer
   import i2ccrc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // input stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] register_address, [15:8] data_byte, [16] first_of_transfer,
   // [17] end_of_register, [23:18] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] command
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] out_byte, [8] crc_match, [9] transfer_ok, [15:10] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] is_crc_byte
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // Configuration register
   logic [DEV_ADDR_W-1:0] dev_addr_ff;
   logic [DEV_ADDR_W-1:0] dev_addr_in;
   // Prefix constants derived from the device address
   logic [7:0]            seed_wr_ff, seed_wr_in;
   logic [7:0]            seed_rd_ff, seed_rd_in;

   // Input register
   logic                  in_valid_ff, in_valid_in;
   req_item_type          in_item_ff, in_item_in;

   // CRC state
   logic [7:0]            running_crc_ff, running_crc_in;
   logic                  transfer_good_ff, transfer_good_in;

   // Result register and second result slot
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_item_type          rsp_item_ff, rsp_item_in;
   logic                  pend_valid_ff, pend_valid_in;
   rsp_item_type          pend_item_ff, pend_item_in;

   logic                  out_free;
   logic                  advance;
   logic                  cfg_write;
   logic [7:0]            addr_w;
   logic                  is_read;
   logic                  close;
   logic [7:0]            reg_t1, reg_t2, reg_t3;
   logic [7:0]            crc_new;
   logic                  match;
   logic                  good_next;
   rsp_item_type          res0, res1;
   logic                  two_results;

   // Configuration write and read back
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == CSR_DEVICE_ADDRESS);
   assign dev_addr_in = cfg_write ? csr_pwdata[DEV_ADDR_W-1:0] : dev_addr_ff;

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == CSR_DEVICE_ADDRESS) begin
         csr_prdata[DEV_ADDR_W-1:0] = dev_addr_ff;
      end
   end

   // Precompute the prefix contribution: write seeds with addr, reg;
   // read adds (addr|1). CRC is linear, so the prefix splits into parts.
   assign addr_w     = {dev_addr_ff, 1'b0};
   assign seed_wr_in = crc_feed(crc_feed(crc_feed(8'h00, addr_w), 8'h00), 8'h00);
   assign seed_rd_in = crc_feed(seed_wr_in, 8'h00)
                       ^ crc_feed(crc_feed(8'h00, addr_w | 8'h01), 8'h00);

   // Handshake: take a new item whenever the input register is empty or moves on
   assign out_free   = !rsp_valid_ff || (rsp_tready && !pend_valid_ff);
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_item_in  = in_item_ff;
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in                  = 1'b1;
         in_item_in.command           = req_tuser;
         in_item_in.register_address  = req_tdata[7:0];
         in_item_in.data_byte         = req_tdata[15:8];
         in_item_in.first_of_transfer = req_tdata[16];
         in_item_in.end_of_register   = req_tdata[17];
         in_item_in.end_of_transfer   = req_tlast;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // CRC update for the registered item
   assign is_read = (in_item_ff.command == CMD_READ);
   assign close   = in_item_ff.end_of_register || in_item_ff.end_of_transfer;
   assign reg_t1  = crc_feed(8'h00, in_item_ff.register_address);
   assign reg_t2  = crc_feed(reg_t1, 8'h00);
   assign reg_t3  = crc_feed(reg_t2, 8'h00);

   always_comb begin
      if (in_item_ff.first_of_transfer) begin
         crc_new = crc_feed(8'h00, in_item_ff.data_byte)
                   ^ (is_read ? (seed_rd_ff ^ reg_t3) : (seed_wr_ff ^ reg_t2));
      end else begin
         crc_new = crc_feed(running_crc_ff, in_item_ff.data_byte);
      end
   end

   assign match     = is_read && close && (crc_new == 8'h00);
   assign good_next = (in_item_ff.first_of_transfer || transfer_good_ff)
                      && !(is_read && close && !match);

   // Build the one or two results of this item
   always_comb begin
      res0.out_byte    = in_item_ff.data_byte;
      res0.is_crc_byte = is_read && close;
      res0.crc_match   = match;
      res0.transfer_ok = is_read && good_next;
      res0.last        = is_read || !close;
      res1.out_byte    = crc_new;
      res1.is_crc_byte = 1'b1;
      res1.crc_match   = 1'b0;
      res1.transfer_ok = 1'b0;
      res1.last        = 1'b1;
      two_results      = !is_read && close;
   end

   // Advance CRC state only when the item moves to the output
   always_comb begin
      running_crc_in   = running_crc_ff;
      transfer_good_in = transfer_good_ff;
      if (advance) begin
         running_crc_in   = close ? 8'h00 : crc_new;
         transfer_good_in = good_next;
      end
   end

   // Output register: load a new item, else shift the pending CRC byte up
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_item_in   = rsp_item_ff;
      pend_valid_in = pend_valid_ff;
      pend_item_in  = pend_item_ff;
      if (advance) begin
         rsp_valid_in  = 1'b1;
         rsp_item_in   = res0;
         pend_valid_in = two_results;
         pend_item_in  = res1;
      end else if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in  = pend_valid_ff;
         rsp_item_in   = pend_item_ff;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff      <= '0;
         in_valid_ff      <= 1'b0;
         running_crc_ff   <= 8'h00;
         transfer_good_ff <= 1'b1;
         rsp_valid_ff     <= 1'b0;
         pend_valid_ff    <= 1'b0;
      end else begin
         dev_addr_ff      <= dev_addr_in;
         in_valid_ff      <= in_valid_in;
         running_crc_ff   <= running_crc_in;
         transfer_good_ff <= transfer_good_in;
         rsp_valid_ff     <= rsp_valid_in;
         pend_valid_ff    <= pend_valid_in;
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      seed_wr_ff   <= seed_wr_in;
      seed_rd_ff   <= seed_rd_in;
      in_item_ff   <= in_item_in;
      rsp_item_ff  <= rsp_item_in;
      pend_item_ff <= pend_item_in;
   end

   // Drive result ports
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_item_ff.transfer_ok, rsp_item_ff.crc_match,
                        rsp_item_ff.out_byte};
   assign rsp_tuser  = rsp_item_ff.is_crc_byte;
   assign rsp_tlast  = rsp_item_ff.last;

`ifndef SYNTHESIS
   // The second slot only fills behind a waiting result
   a_pend_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> rsp_valid_ff)
      else $error("pending result without a result in front");

   // A non-final result always has its CRC byte queued behind it
   a_not_last_has_pend: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_item_ff.last) |-> pend_valid_ff)
      else $error("non-final result without a queued CRC byte");

   // A closing write item queues its generated CRC byte
   a_write_close_pend: assert property (@(posedge clock) disable iff (reset)
      (advance && !is_read && close) |=> (pend_valid_ff && pend_item_ff.is_crc_byte))
      else $error("closing write item did not queue a CRC byte");

   // Closing a register restarts the CRC at zero
   a_close_clears_crc: assert property (@(posedge clock) disable iff (reset)
      (advance && close) |=> (running_crc_ff == 8'h00))
      else $error("running CRC not cleared after a closed register");
`endif

endmodule
